/* sv/wcapf_pkg.sv */
// Shared constants for the WCA pair force accumulator.
// Used by the serial multiplier, the serial divider and the top level.
package wcapf_pkg;

  localparam int POS_FRAC_BITS_DEFAULT = 16;
  localparam int POS_INT_BITS_DEFAULT  = 8;

  // Serial multiplier operand widths: A is held, B is scanned one bit a cycle.
  localparam int MUL_A_W = 52;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider: dividend is 24*(2-s3) in Q.30 shifted up by 16 bits.
  // The divisor s^7 in Q.30 reaches just over 5.0, so it needs 33 bits.
  localparam int DIV_N_W = 52;
  localparam int DIV_D_W = 33;

  // floor(2^(1/3) * 2^30), the squared cutoff in Q.30.
  localparam logic [30:0] CUT_Q30 = 31'd1352829926;

  // Register indexes on the configuration port.
  localparam logic REG_BOX_WIDTH  = 1'b0;
  localparam logic REG_BOX_HEIGHT = 1'b1;

  // Periodic wrap codes.
  localparam logic [1:0] WRAP_NONE = 2'b00;
  localparam logic [1:0] WRAP_POS  = 2'b01;
  localparam logic [1:0] WRAP_NEG2 = 2'b10;
  localparam logic [1:0] WRAP_NEG  = 2'b11;

endpackage

/* sv/wca_pair_force_accumulator.sv */
// WCA pair force accumulator: top level with the pair sequencer.
// Depends on wcapf_pkg, wcapf_serial_mul and wcapf_serial_div.
//
// Usage:
//   Feed one word per neighbour of a target on the input channel (in_valid /
//   in_ready). Each word carries both positions, the wrap codes and the
//   self and last flags. The word marked last produces one result word on
//   the output channel (out_valid / out_ready): the saturated force sum and
//   a sticky saturation flag; the sums are then cleared.
//   Box sizes are written on cfg_we / cfg_index / cfg_data while idle.
// Flow:
//   A pair in range runs through one shared bit-serial multiplier (up to
//   nine products) and a restoring divider. A self pair or one beyond the
//   early cut skips both; one rejected after the squared distance uses only
//   the two squaring products. The serial multiplier sets the rate.
// Reset: sums and flag clear, box sizes go to all ones, no word pending.
// Stall: the result sits in an output register; the next neighbour is
//   accepted meanwhile, and a following last word holds until it is taken.
module wca_pair_force_accumulator #(
  parameter int POSITION_FRACTION_BITS = wcapf_pkg::POS_FRAC_BITS_DEFAULT,
  parameter int POSITION_INTEGER_BITS  = wcapf_pkg::POS_INT_BITS_DEFAULT
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_we,
  input  logic                                              cfg_index,
  input  logic [POSITION_INTEGER_BITS+POSITION_FRACTION_BITS-1:0] cfg_data,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [POSITION_INTEGER_BITS+POSITION_FRACTION_BITS-1:0] target_x,
  input  logic [POSITION_INTEGER_BITS+POSITION_FRACTION_BITS-1:0] target_y,
  input  logic [POSITION_INTEGER_BITS+POSITION_FRACTION_BITS-1:0] other_x,
  input  logic [POSITION_INTEGER_BITS+POSITION_FRACTION_BITS-1:0] other_y,
  input  logic signed [1:0]                                 wrap_x,
  input  logic signed [1:0]                                 wrap_y,
  input  logic                                              is_self,
  input  logic                                              is_last,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic signed [31:0]                                force_x,
  output logic signed [31:0]                                force_y,
  output logic                                              saturated
);
  import wcapf_pkg::*;

  localparam int PF  = POSITION_FRACTION_BITS;
  localparam int PW  = POSITION_INTEGER_BITS + POSITION_FRACTION_BITS;
  localparam int DW  = PW + 3;            // signed difference incl. wrap
  localparam int MW  = PF + 1;            // magnitude after the early cut
  localparam int R2W = 2 * PF + 3;        // exact squared distance
  localparam int SHL = (2 * PF >= 30) ? 0 : 30 - 2 * PF;
  localparam int SHR = (2 * PF >= 30) ? 2 * PF - 30 : 0;
  localparam int SW  = R2W + SHL;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_CUT, ST_S2, ST_S3, ST_S4, ST_S6, ST_S7,
    ST_DIV, ST_TXS, ST_TXW, ST_TYS, ST_TYW, ST_ACC, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } term_t;

  state_t state;

  logic [PW-1:0] box_width;
  logic [PW-1:0] box_height;

  // Pair registers.
  logic          neg_x, neg_y, zero_x, zero_y, last;
  logic [MW-1:0] mag_x, mag_y;
  logic [R2W-1:0] r2;
  logic [30:0]   s, s2, s3;
  logic          inf;
  logic [DIV_N_W-1:0] f;
  logic [31:0]   term_x, term_y;
  logic          pair_sat;

  logic signed [31:0] sum_x, sum_y;
  logic               sat_seen;

  // Shared units.
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_n, div_q;
  logic [DIV_D_W-1:0] div_d;

  wcapf_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  wcapf_serial_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(div_d),
    .done(div_done), .q(div_q)
  );

  // Difference vector d = target - other - wrap * box, modulo 2^DW.
  function automatic logic [DW-1:0] wrap_term(logic [1:0] w, logic [PW-1:0] box);
    logic [DW-1:0] b;
    logic [DW-1:0] r;
    b = DW'(box);
    case (w)
      WRAP_POS:  r = b;
      WRAP_NEG:  r = ~b + DW'(1);
      WRAP_NEG2: r = ~(b << 1) + DW'(1);
      default:   r = '0;
    endcase
    return r;
  endfunction

  logic [DW-1:0] dx_in, dy_in, ax_in, ay_in;
  logic          cut_in;

  assign dx_in = DW'(target_x) - DW'(other_x) - wrap_term(wrap_x, box_width);
  assign dy_in = DW'(target_y) - DW'(other_y) - wrap_term(wrap_y, box_height);
  assign ax_in = dx_in[DW-1] ? (~dx_in + DW'(1)) : dx_in;
  assign ay_in = dy_in[DW-1] ? (~dy_in + DW'(1)) : dy_in;
  // Drop the pair when either component reaches 2.0.
  assign cut_in = (|ax_in[DW-1:PF+1]) || (|ay_in[DW-1:PF+1]);

  // Squared distance rescaled to Q.30.
  logic [SW-1:0] s_full;
  assign s_full = (SW'(r2) << SHL) >> SHR;

  // 24 * (2 - s3), then shifted up 16 for the Q.16 quotient.
  logic [31:0] two_minus_s3;
  logic [35:0] num;
  assign two_minus_s3 = 32'h8000_0000 - {1'b0, s3};
  assign num = (36'(two_minus_s3) << 4) + (36'(two_minus_s3) << 3);

  function automatic logic [31:0] sat_value(logic neg);
    return neg ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic term_t make_term(logic [MUL_P_W-1:0] p, logic neg);
    term_t t;
    logic [30:0] m;
    m = p[PF+30:PF];
    if (|(p >> (PF + 31))) begin
      t.value = sat_value(neg);
      t.sat   = 1'b1;
    end else begin
      t.value = neg ? (~{1'b0, m} + 32'd1) : {1'b0, m};
      t.sat   = 1'b0;
    end
    return t;
  endfunction

  function automatic term_t add_sat(logic [31:0] a, logic [31:0] b);
    term_t t;
    logic [32:0] sum;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      t.value = sat_value(sum[32]);
      t.sat   = 1'b1;
    end else begin
      t.value = sum[31:0];
      t.sat   = 1'b0;
    end
    return t;
  endfunction

  term_t acc_x, acc_y, prod_term;
  assign acc_x     = add_sat(sum_x, term_x);
  assign acc_y     = add_sat(sum_y, term_y);
  assign prod_term = make_term(mul_p, (state == ST_TXW) ? neg_x : neg_y);

  assign in_ready = (state == ST_IDLE);

  // Start pulses last one cycle: each wait state drops them while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      box_width  <= '1;
      box_height <= '1;
      sum_x      <= '0;
      sum_y      <= '0;
      sat_seen   <= 1'b0;
      out_valid  <= 1'b0;
      mul_start  <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOX_WIDTH:  box_width  <= cfg_data;
          REG_BOX_HEIGHT: box_height <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last     <= is_last;
            neg_x    <= dx_in[DW-1];
            neg_y    <= dy_in[DW-1];
            zero_x   <= (dx_in == '0);
            zero_y   <= (dy_in == '0);
            mag_x    <= ax_in[MW-1:0];
            mag_y    <= ay_in[MW-1:0];
            term_x   <= '0;
            term_y   <= '0;
            pair_sat <= 1'b0;
            if (is_self || cut_in) begin
              state <= ST_ACC;
            end else begin
              mul_a     <= MUL_A_W'(ax_in[MW-1:0]);
              mul_b     <= MUL_B_W'(ax_in[MW-1:0]);
              mul_start <= 1'b1;
              state     <= ST_SQX;
            end
          end
        end
        ST_SQX: if (mul_done) begin
          r2        <= R2W'(mul_p);
          mul_a     <= MUL_A_W'(mag_y);
          mul_b     <= MUL_B_W'(mag_y);
          mul_start <= 1'b1;
          state     <= ST_SQY;
        end else mul_start <= 1'b0;
        ST_SQY: if (mul_done) begin
          r2    <= r2 + R2W'(mul_p);
          state <= ST_CUT;
        end else mul_start <= 1'b0;
        ST_CUT: begin
          if (s_full > SW'(CUT_Q30)) begin
            state <= ST_ACC;
          end else begin
            s         <= s_full[30:0];
            mul_a     <= MUL_A_W'(s_full[30:0]);
            mul_b     <= MUL_B_W'(s_full[30:0]);
            mul_start <= 1'b1;
            state     <= ST_S2;
          end
        end
        ST_S2: if (mul_done) begin
          s2        <= mul_p[60:30];
          mul_a     <= MUL_A_W'(mul_p[60:30]);
          mul_b     <= MUL_B_W'(s);
          mul_start <= 1'b1;
          state     <= ST_S3;
        end else mul_start <= 1'b0;
        ST_S3: if (mul_done) begin
          s3        <= mul_p[60:30];
          mul_a     <= MUL_A_W'(s2);
          mul_b     <= MUL_B_W'(s2);
          mul_start <= 1'b1;
          state     <= ST_S4;
        end else mul_start <= 1'b0;
        // s^4 and s^6 run past 2.0 in Q.30, so keep 32 bits of them.
        ST_S4: if (mul_done) begin
          mul_a     <= MUL_A_W'(mul_p[61:30]);
          mul_b     <= MUL_B_W'(s2);
          mul_start <= 1'b1;
          state     <= ST_S6;
        end else mul_start <= 1'b0;
        ST_S6: if (mul_done) begin
          mul_a     <= MUL_A_W'(mul_p[61:30]);
          mul_b     <= MUL_B_W'(s);
          mul_start <= 1'b1;
          state     <= ST_S7;
        end else mul_start <= 1'b0;
        ST_S7: if (mul_done) begin
          // A vanishing s^7 saturates every nonzero component.
          if (mul_p[62:30] == '0) begin
            inf   <= 1'b1;
            state <= ST_TXS;
          end else begin
            inf       <= 1'b0;
            div_n     <= {num, 16'b0};
            div_d     <= mul_p[62:30];
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end else mul_start <= 1'b0;
        ST_DIV: if (div_done) begin
          f     <= div_q;
          state <= ST_TXS;
        end else div_start <= 1'b0;
        ST_TXS: begin
          if (zero_x || (!inf && f == '0)) begin
            term_x <= '0;
            state  <= ST_TYS;
          end else if (inf) begin
            term_x   <= sat_value(neg_x);
            pair_sat <= 1'b1;
            state    <= ST_TYS;
          end else begin
            mul_a     <= f;
            mul_b     <= MUL_B_W'(mag_x);
            mul_start <= 1'b1;
            state     <= ST_TXW;
          end
        end
        ST_TXW: if (mul_done) begin
          term_x   <= prod_term.value;
          pair_sat <= pair_sat | prod_term.sat;
          state    <= ST_TYS;
        end else mul_start <= 1'b0;
        ST_TYS: begin
          if (zero_y || (!inf && f == '0)) begin
            term_y <= '0;
            state  <= ST_ACC;
          end else if (inf) begin
            term_y   <= sat_value(neg_y);
            pair_sat <= 1'b1;
            state    <= ST_ACC;
          end else begin
            mul_a     <= f;
            mul_b     <= MUL_B_W'(mag_y);
            mul_start <= 1'b1;
            state     <= ST_TYW;
          end
        end
        ST_TYW: if (mul_done) begin
          term_y   <= prod_term.value;
          pair_sat <= pair_sat | prod_term.sat;
          state    <= ST_ACC;
        end else mul_start <= 1'b0;
        ST_ACC: begin
          sum_x    <= acc_x.value;
          sum_y    <= acc_y.value;
          sat_seen <= sat_seen | pair_sat | acc_x.sat | acc_y.sat;
          state    <= last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          // Hold until the output register is free, then emit and clear.
          if (!out_valid || out_ready) begin
            force_x   <= sum_x;
            force_y   <= sum_y;
            saturated <= sat_seen;
            out_valid <= 1'b1;
            sum_x     <= '0;
            sum_y     <= '0;
            sat_seen  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // One neighbour at a time: an accepted word closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a pair is in flight");

  // Products only return while the sequencer waits for them.
  a_mul_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_SQX || state == ST_SQY || state == ST_S2 ||
                  state == ST_S3 || state == ST_S4 || state == ST_S6 ||
                  state == ST_S7 || state == ST_TXW || state == ST_TYW))
    else $error("multiplier result with no consumer");

  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider result with no consumer");

  // A result is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_valid && !out_ready |=> state == ST_EMIT)
    else $error("pending result overwritten");

endmodule

/* sv/wcapf_serial_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on wcapf_pkg for operand widths.
module wcapf_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wcapf_pkg::MUL_A_W-1:0] a,
  input  logic [wcapf_pkg::MUL_B_W-1:0] b,
  output logic                          done,
  output logic [wcapf_pkg::MUL_P_W-1:0] p
);
  import wcapf_pkg::*;

  localparam int CW = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] a_hold;
  logic [CW-1:0]      count;
  logic               busy;
  logic [MUL_A_W:0]   partial;

  // Add the held operand to the upper half when the low bit is set.
  assign partial = {1'b0, p[MUL_P_W-1:MUL_B_W]} + (p[0] ? {1'b0, a_hold} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CW'(MUL_B_W - 1));
      if (start) begin
        a_hold <= a;
        p      <= {{MUL_A_W{1'b0}}, b};
        count  <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        p <= {partial, p[MUL_B_W-1:1]};
        if (count == CW'(MUL_B_W - 1)) begin
          busy <= 1'b0;
        end
        count <= count + CW'(1);
      end
    end
  end

endmodule

/* sv/wcapf_serial_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on wcapf_pkg for dividend and divisor widths.
module wcapf_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wcapf_pkg::DIV_N_W-1:0] n,
  input  logic [wcapf_pkg::DIV_D_W-1:0] d,
  output logic                          done,
  output logic [wcapf_pkg::DIV_N_W-1:0] q
);
  import wcapf_pkg::*;

  localparam int CW = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] d_hold;
  logic [DIV_D_W:0]   rem;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic [CW-1:0]      count;
  logic               busy;

  assign trial = {rem[DIV_D_W-1:0], q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, d_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CW'(DIV_N_W - 1));
      if (start) begin
        d_hold <= d;
        q      <= n;
        rem    <= '0;
        count  <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, d_hold}) begin
          rem <= diff;
          q   <= {q[DIV_N_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[DIV_N_W-2:0], 1'b0};
        end
        if (count == CW'(DIV_N_W - 1)) begin
          busy <= 1'b0;
        end
        count <= count + CW'(1);
      end
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the WCA pair force accumulator.
// Depends on wcapf_pkg and wca_pair_force_accumulator; reads no files.
// Runs a directed table, then random neighbour streams under several box sizes.
`timescale 1ns / 100ps

module testbench;
  import wcapf_pkg::*;

  localparam int PW = 24;
  localparam int FB = 16;
  localparam longint unsigned CUT = 64'd1352829926;
  localparam longint unsigned LIMIT_CYCLES = 4000000;
  localparam int SETTLE = 450;      // wait for an in-range pair to finish
  localparam int RANDOM_PER_PHASE = 280;

  typedef struct {
    logic [PW-1:0]      tx, ty, ox, oy;
    logic [1:0]         wx, wy;
    logic               self_flag, last_flag;
    logic               known;    // expected result typed into the row
    logic signed [31:0] fx, fy;
    logic               sat;
  } nbr_row_t;

  typedef struct {
    logic signed [31:0] fx, fy;
    logic               sat;
  } force_word_t;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [PW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [PW-1:0] target_x, target_y, other_x, other_y;
  logic signed [1:0] wrap_x, wrap_y;
  logic is_self, is_last;
  logic out_valid, out_ready;
  logic signed [31:0] force_x, force_y;
  logic saturated;

  // Predictor state: box registers and the running sums.
  longint unsigned box_w, box_h;
  int              sum_fx, sum_fy;
  bit              sum_sat;

  force_word_t     pending_forces[$];
  nbr_row_t        directed_rows[$];
  int              mismatches = 0;
  longint unsigned cycles = 0;
  bit              steady;            // no idling on either side

  wca_pair_force_accumulator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .target_x(target_x), .target_y(target_y),
    .other_x(other_x), .other_y(other_y),
    .wrap_x(wrap_x), .wrap_y(wrap_y),
    .is_self(is_self), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .force_x(force_x), .force_y(force_y), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("wca_pair_force_accumulator: mismatch");
      $finish;
    end
  end

  // Sign-extend a two-bit wrap code; binary 10 reads as -2.
  function automatic longint wrap_value(logic [1:0] w);
    return w[1] ? longint'(w) - 4 : longint'(w);
  endfunction

  // One force component, saturated to int32 when the product is too large or s^7 vanishes.
  function automatic longint component_force(longint d, longint unsigned f, bit inf,
                                             inout bit sat);
    longint unsigned mag, lim, m;
    if (d == 0) return 0;
    mag = d < 0 ? longint'(-d) : longint'(d);
    if (!inf) begin
      if (f == 0) return 0;
      lim = ((64'd1 << (31 + FB)) - 1) / f;
      if (mag <= lim) begin
        m = (mag * f) >> FB;
        return d < 0 ? -longint'(m) : longint'(m);
      end
    end
    sat = 1'b1;
    return d < 0 ? -64'sd2147483648 : 64'sd2147483647;
  endfunction

  function automatic int clamp_sum(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  // Add one neighbour's repulsion to the running sums.
  task automatic add_repulsion(longint dx, longint dy);
    longint lim2, tx, ty;
    longint unsigned ax, ay, s, s2, s3, s4, s6, s7, num, f;
    bit sat, inf;
    lim2 = 64'sd2 << FB;
    sat = 1'b0;
    f = 0;
    if (dx >= lim2 || dx <= -lim2 || dy >= lim2 || dy <= -lim2) return;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = (ax * ax + ay * ay) >> (2 * FB - 30);
    if (s > CUT) return;
    s2 = (s * s) >> 30;
    s3 = (s2 * s) >> 30;
    s4 = (s2 * s2) >> 30;
    s6 = (s4 * s2) >> 30;
    s7 = (s6 * s) >> 30;
    num = 24 * ((64'd2 << 30) - s3);
    inf = (s7 == 0);
    if (!inf) f = (num << 16) / s7;
    tx = component_force(dx, f, inf, sat);
    ty = component_force(dy, f, inf, sat);
    sum_fx = clamp_sum(longint'(sum_fx) + tx, sat);
    sum_fy = clamp_sum(longint'(sum_fy) + ty, sat);
    if (sat) sum_sat = 1'b1;
  endtask

  // Update the sums for an accepted word; queue the force word on a last one.
  task automatic predict_word(nbr_row_t r);
    force_word_t w;
    if (!r.self_flag)
      add_repulsion(longint'(r.tx) - longint'(r.ox) - wrap_value(r.wx) * longint'(box_w),
                    longint'(r.ty) - longint'(r.oy) - wrap_value(r.wy) * longint'(box_h));
    if (!r.last_flag) return;
    w.fx = sum_fx;
    w.fy = sum_fy;
    w.sat = sum_sat;
    if (r.known) begin
      w.fx = r.fx;
      w.fy = r.fy;
      w.sat = r.sat;
    end
    pending_forces.push_back(w);
    sum_fx = 0;
    sum_fy = 0;
    sum_sat = 1'b0;
  endtask

  // Present one word, hold it until accepted, then predict.
  task automatic send_word(nbr_row_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) begin
        @(posedge clk);
        @(negedge clk);
      end
    end
    target_x = r.tx;
    target_y = r.ty;
    other_x = r.ox;
    other_y = r.oy;
    wrap_x = r.wx;
    wrap_y = r.wy;
    is_self = r.self_flag;
    is_last = r.last_flag;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_word(r);
    @(negedge clk);
  endtask

  // Drain all results and let the pair engine settle, then write the boxes.
  task automatic set_boxes(logic [PW-1:0] w, logic [PW-1:0] h);
    in_valid = 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_BOX_WIDTH;
    cfg_data = w;
    @(negedge clk);
    cfg_index = REG_BOX_HEIGHT;
    cfg_data = h;
    @(negedge clk);
    cfg_we = 1'b0;
    box_w = 64'(w);
    box_h = 64'(h);
  endtask

  task automatic add_row(logic [PW-1:0] tx, ty, ox, oy, logic [1:0] wx, wy,
                         logic sf, lf, logic known = 0,
                         logic signed [31:0] fx = 0, fy = 0, logic sat = 0);
    nbr_row_t r;
    r = '{tx, ty, ox, oy, wx, wy, sf, lf, known, fx, fy, sat};
    directed_rows.push_back(r);
  endtask

  // Pick the neighbour coordinate so target - other - wrap*box lands near off.
  function automatic void place_axis(logic [PW-1:0] t, longint off, longint unsigned box,
                                     output logic [PW-1:0] o, output logic [1:0] w);
    longint v;
    w = 2'($urandom_range(0, 3));
    v = longint'(t) - off - wrap_value(w) * longint'(box);
    if (v < 0 || v >= (64'sd1 << PW)) begin
      w = WRAP_NONE;
      v = longint'(t) - off;
    end
    if (v < 0 || v >= (64'sd1 << PW)) v = longint'($urandom_range(0, (1 << PW) - 1));
    o = v[PW-1:0];
  endfunction

  function automatic nbr_row_t random_row();
    nbr_row_t r;
    int kind;
    longint offx, offy;
    kind = $urandom_range(0, 99);
    r.tx = PW'($urandom_range(0, (1 << PW) - 1));
    r.ty = PW'($urandom_range(0, (1 << PW) - 1));
    r.ox = PW'($urandom_range(0, (1 << PW) - 1));
    r.oy = PW'($urandom_range(0, (1 << PW) - 1));
    r.wx = 2'($urandom_range(0, 3));
    r.wy = 2'($urandom_range(0, 3));
    r.self_flag = (kind < 8);
    r.last_flag = ($urandom_range(0, 5) == 0);
    r.known = 1'b0;
    r.fx = 0;
    r.fy = 0;
    r.sat = 0;
    if (kind >= 15) begin
      // close pair; a few land so close the term saturates
      if (kind >= 92) begin
        offx = longint'($urandom_range(0, 400)) - 200;
        offy = longint'($urandom_range(0, 400)) - 200;
      end else begin
        offx = longint'($urandom_range(0, 180000)) - 90000;
        offy = longint'($urandom_range(0, 180000)) - 90000;
      end
      place_axis(r.tx, offx, box_w, r.ox, r.wx);
      place_axis(r.ty, offy, box_h, r.oy, r.wy);
    end
    return r;
  endfunction

  // Output side: stall a random number of cycles before each word.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      out_ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  // Compare each force word against the oldest prediction.
  always @(posedge clk) begin
    force_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected force word fx=%0d fy=%0d sat=%0b",
                   force_x, force_y, saturated);
      end else begin
        e = pending_forces.pop_front();
        if (force_x !== e.fx || force_y !== e.fy || saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("force word: exp fx=%0d fy=%0d sat=%0b got fx=%0d fy=%0d sat=%0b",
                     e.fx, e.fy, e.sat, force_x, force_y, saturated);
        end
      end
    end
  end

  initial begin
    logic [PW-1:0] boxes_w[4];
    logic [PW-1:0] boxes_h[4];
    steady = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BOX_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    target_x = '0;
    target_y = '0;
    other_x = '0;
    other_y = '0;
    wrap_x = WRAP_NONE;
    wrap_y = WRAP_NONE;
    is_self = 1'b0;
    is_last = 1'b0;
    box_w = 64'hffffff;
    box_h = 64'hffffff;
    sum_fx = 0;
    sum_fy = 0;
    sum_sat = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; rows with known=1 carry the force word by hand.
    add_row(24'h010000, 24'h010000, 24'h010000, 24'h010000, WRAP_NONE, WRAP_NONE,
            1, 1, 1, 0, 0, 0);                                       // self only
    add_row(24'h000000, 24'h000000, 24'h020000, 24'h000000, WRAP_NONE, WRAP_NONE,
            0, 1, 1, 0, 0, 0);                                       // early cut
    add_row(24'h050000, 24'h050000, 24'h050000, 24'h050000, WRAP_NONE, WRAP_NONE,
            0, 1, 1, 0, 0, 0);                                       // coincident
    add_row(24'h010001, 24'h010000, 24'h010000, 24'h010000, WRAP_NONE, WRAP_NONE,
            0, 1, 1, 32'sh7fffffff, 0, 1);                           // vanishing s^7
    add_row(24'h010000, 24'h010000, 24'h010001, 24'h010000, WRAP_NONE, WRAP_NONE,
            0, 1, 1, 32'sh80000000, 0, 1);
    add_row(24'h010000, 24'h010001, 24'h010000, 24'h010000, WRAP_NONE, WRAP_NONE, 0, 0);
    add_row(24'h010000, 24'h010002, 24'h010000, 24'h010000, WRAP_NONE, WRAP_NONE,
            0, 1, 1, 0, 32'sh7fffffff, 1);                           // sum overflow
    add_row(24'h010000, 24'h010000, 24'h00c000, 24'h010000, WRAP_NONE, WRAP_NONE, 0, 1);
    add_row(24'h010000, 24'h010000, 24'h00e000, 24'h00f000, WRAP_NONE, WRAP_NONE, 0, 0);
    add_row(24'h020000, 24'h020000, 24'h02f000, 24'h01a000, WRAP_NONE, WRAP_NONE, 0, 1);
    add_row(24'h010000, 24'h010000, 24'h00f000, 24'h010000, WRAP_NONE, WRAP_NONE, 0, 1);
    add_row(24'h010000, 24'h010000, 24'h00ee00, 24'h010000, WRAP_NONE, WRAP_NONE, 0, 1);
    add_row(24'h000100, 24'h000000, 24'hffff00, 24'h000000, WRAP_NEG, WRAP_NONE, 0, 1);
    add_row(24'h000000, 24'hffff00, 24'h000000, 24'h000100, WRAP_NONE, WRAP_POS, 0, 1);
    add_row(24'h000000, 24'h000000, 24'hffffff, 24'hffffff, WRAP_NEG2, WRAP_NEG2, 0, 1);
    add_row(24'hffffff, 24'hffffff, 24'h000000, 24'h000000, WRAP_POS, WRAP_POS, 0, 1);
    add_row(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, WRAP_NONE, WRAP_NONE, 1, 0);
    add_row(24'h000000, 24'h000000, 24'h000000, 24'h000000, WRAP_NONE, WRAP_NONE, 0, 1);
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // Box extremes: one, all ones, zero, and a small typical box.
    boxes_w = '{24'h000001, 24'hffffff, 24'h000000, 24'h030000};
    boxes_h = '{24'hffffff, 24'h000001, 24'h012345, 24'h028000};
    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_boxes(boxes_w[p-1], boxes_h[p-1]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % 70 == 0) steady = ($urandom_range(0, 3) == 0);
        send_word(random_row());
      end
    end
    in_valid = 1'b0;
    steady = 1'b0;

    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_forces.size() == 0)
      $display("wca_pair_force_accumulator: match");
    else
      $display("wca_pair_force_accumulator: mismatch");
    $finish;
  end

endmodule
